// ===== design/stt_pkg.sv =====
// Shared types, operation codes and defaults for the soft timer table.
`timescale 1ns / 1ps

package stt_pkg;

  // Fixed field widths of the request and result channels.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned TASK_W    = 3;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned FLAGS_W   = 5;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_NUM_SLOTS  = 5;
  localparam int unsigned DEF_NUM_TASKS  = 5;
  localparam int unsigned DEF_COUNT_BITS = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ARM   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tick;            // decrement or expire every busy slot
    logic arm;             // reload or claim a slot for the request's task
    logic clear;           // lower the request's pending flag
    logic head_new;        // load the fresh result into the head entry
    logic head_from_tail;  // advance the tail entry into the head entry
    logic tail_new;        // load the fresh result into the tail entry
  } stt_cmd_t;

  // One result entry of the output queue.
  typedef struct packed {
    logic [FLAGS_W-1:0] pending_flags;
    logic [FLAGS_W-1:0] expired_now;
    logic               set_dropped;
  } stt_res_t;

endpackage

// ===== design/soft_timer_table.sv =====
// Top level of the soft timer table: controller plus slot datapath.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// request   in         in_valid_i / in_stall_o    op_i, task_id_i, delay_i
// result    out        out_valid_o / out_stall_i  pending_flags_o, expired_now_o, set_dropped_o
//
// Every slot compares and decrements in its own lane, and the result of each
// request is written into a two-entry output queue at the same edge that
// takes the request.
// A request is taken every cycle until both queue entries hold results.
// Reset frees every slot and lowers every pending flag; slot task and count
// storage is written on claim and needs no reset.
// A stalled result holds in the queue head; requests keep flowing until the
// tail entry fills too, then in_stall_o rises.

module soft_timer_table #(
  parameter int unsigned NUM_SLOTS  = stt_pkg::DEF_NUM_SLOTS,
  parameter int unsigned NUM_TASKS  = stt_pkg::DEF_NUM_TASKS,
  parameter int unsigned COUNT_BITS = stt_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Request channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [stt_pkg::OP_W-1:0]     op_i,
  input  logic [stt_pkg::TASK_W-1:0]   task_id_i,
  input  logic [stt_pkg::DELAY_W-1:0]  delay_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [stt_pkg::FLAGS_W-1:0]  pending_flags_o,
  output logic [stt_pkg::FLAGS_W-1:0]  expired_now_o,
  output logic                         set_dropped_o
);
  import stt_pkg::*;

  stt_cmd_t cmd;

  // Decode the request, gate it by acceptance, and track queue occupancy.
  stt_ctrl #(
    .NUM_TASKS (NUM_TASKS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .task_id_i   (task_id_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Slot lanes, pending flags and the result queue storage.
  stt_datapath #(
    .NUM_SLOTS  (NUM_SLOTS),
    .NUM_TASKS  (NUM_TASKS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .task_id_i       (task_id_i),
    .delay_i         (delay_i),
    .pending_flags_o (pending_flags_o),
    .expired_now_o   (expired_now_o),
    .set_dropped_o   (set_dropped_o)
  );

endmodule

// ===== design/stt_ctrl.sv =====
// Controller: request decode and output queue occupancy state machine.
`timescale 1ns / 1ps

module stt_ctrl #(
  parameter int unsigned NUM_TASKS = stt_pkg::DEF_NUM_TASKS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [stt_pkg::OP_W-1:0]   op_i,
  input  logic [stt_pkg::TASK_W-1:0] task_id_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output stt_pkg::stt_cmd_t          cmd_o
);
  import stt_pkg::*;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_ONE   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;
  logic       pop;
  logic       task_ok;
  logic [5:0] task_ext;

  assign in_stall_o  = (state_q == ST_FULL);
  assign out_valid_o = (state_q != ST_EMPTY);
  assign accept      = in_valid_i && !in_stall_o;
  assign pop         = out_valid_o && !out_stall_i;

  assign task_ext = 6'(task_id_i);
  assign task_ok  = task_ext < 6'(NUM_TASKS);

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cmd_o.tick  = accept && (op_i == OP_TICK);
    cmd_o.arm   = accept && (op_i == OP_ARM) && task_ok;
    cmd_o.clear = accept && (op_i == OP_CLEAR) && task_ok;
    unique case (state_q)
      ST_EMPTY: begin
        if (accept) begin
          cmd_o.head_new = 1'b1;
          state_d        = ST_ONE;
        end
      end
      ST_ONE: begin
        if (accept && pop) begin
          cmd_o.head_new = 1'b1;
        end else if (accept) begin
          cmd_o.tail_new = 1'b1;
          state_d        = ST_FULL;
        end else if (pop) begin
          state_d = ST_EMPTY;
        end
      end
      ST_FULL: begin
        if (pop) begin
          cmd_o.head_from_tail = 1'b1;
          state_d              = ST_ONE;
        end
      end
      default: begin
        state_d = ST_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.head_new || cmd_o.tail_new) |-> (state_q != ST_FULL))
    else $error("result pushed into a full output queue");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && !accept) |=> $stable(state_q))
    else $error("queue occupancy moved without push or pop");

  a_ops_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.tick, cmd_o.arm, cmd_o.clear}))
    else $error("more than one operation issued at once");

endmodule

// ===== design/stt_datapath.sv =====
// Datapath: slot table, pending flags and the two-entry result queue.
`timescale 1ns / 1ps

module stt_datapath #(
  parameter int unsigned NUM_SLOTS  = stt_pkg::DEF_NUM_SLOTS,
  parameter int unsigned NUM_TASKS  = stt_pkg::DEF_NUM_TASKS,
  parameter int unsigned COUNT_BITS = stt_pkg::DEF_COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  stt_pkg::stt_cmd_t            cmd_i,
  input  logic [stt_pkg::TASK_W-1:0]   task_id_i,
  input  logic [stt_pkg::DELAY_W-1:0]  delay_i,
  output logic [stt_pkg::FLAGS_W-1:0]  pending_flags_o,
  output logic [stt_pkg::FLAGS_W-1:0]  expired_now_o,
  output logic                         set_dropped_o
);
  import stt_pkg::*;

  logic [NUM_SLOTS-1:0]  busy_q, busy_d;
  logic [TASK_W-1:0]     task_q  [NUM_SLOTS];
  logic [TASK_W-1:0]     task_d  [NUM_SLOTS];
  logic [COUNT_BITS-1:0] count_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0] count_d [NUM_SLOTS];
  logic [NUM_TASKS-1:0]  pending_q, pending_d;

  logic [NUM_SLOTS-1:0]  match_vec, free_vec, match_oh, free_oh, claim_oh;
  logic [31:0]           expired32;
  logic [31:0]           clear32;
  logic [31:0]           pend32;
  logic [31:0]           delay32;
  logic                  dropped;
  stt_res_t              res_new, head_q, tail_q;

  assign delay32 = 32'(delay_i);
  assign clear32 = 32'(1) << task_id_i;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      match_vec[i] = busy_q[i] && (task_q[i] == task_id_i);
      free_vec[i]  = !busy_q[i];
    end
  end

  // Lowest set bit of each vector.
  assign match_oh = match_vec & (~match_vec + 1'b1);
  assign free_oh  = free_vec & (~free_vec + 1'b1);
  assign claim_oh = (|match_vec) ? match_oh : free_oh;
  assign dropped  = cmd_i.arm && !(|match_vec) && !(|free_vec);

  always_comb begin
    busy_d    = busy_q;
    expired32 = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      task_d[i]  = task_q[i];
      count_d[i] = count_q[i];
      if (cmd_i.tick && busy_q[i]) begin
        if (count_q[i] == '0) begin
          busy_d[i] = 1'b0;
          expired32 = expired32 | (32'(1) << task_q[i]);
        end else begin
          count_d[i] = count_q[i] - 1'b1;
        end
      end
      if (cmd_i.arm && claim_oh[i]) begin
        busy_d[i]  = 1'b1;
        task_d[i]  = task_id_i;
        count_d[i] = delay32[COUNT_BITS-1:0];
      end
    end
    pending_d = pending_q | expired32[NUM_TASKS-1:0];
    if (cmd_i.clear) begin
      pending_d = pending_q & ~clear32[NUM_TASKS-1:0];
    end
  end

  assign pend32                = 32'(pending_d);
  assign res_new.pending_flags = pend32[FLAGS_W-1:0];
  assign res_new.expired_now   = expired32[FLAGS_W-1:0];
  assign res_new.set_dropped   = dropped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= '0;
      pending_q <= '0;
    end else begin
      busy_q    <= busy_d;
      pending_q <= pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      task_q[i]  <= task_d[i];
      count_q[i] <= count_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_new) begin
      head_q <= res_new;
    end else if (cmd_i.head_from_tail) begin
      head_q <= tail_q;
    end
    if (cmd_i.tail_new) begin
      tail_q <= res_new;
    end
  end

  assign pending_flags_o = head_q.pending_flags;
  assign expired_now_o   = head_q.expired_now;
  assign set_dropped_o   = head_q.set_dropped;

  a_expire_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_new.expired_now != '0) |-> cmd_i.tick)
    else $error("expiry reported outside a tick");

  a_drop_only_on_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_new.set_dropped |-> cmd_i.arm)
    else $error("drop flagged outside an arm");

  a_tick_never_claims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick |=> ((busy_q & ~$past(busy_q)) == '0))
    else $error("tick claimed a slot");

endmodule

// ===== bench/soft_timer_table_tb.sv =====
// Self-checking testbench for the soft timer table: scoreboard, request driver, result monitor.
`timescale 1ns / 1ps

module soft_timer_table_tb;
  import stt_pkg::*;

  // Op code 3 has no function; the block must report state and change nothing.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned NUM_SLOTS  = DEF_NUM_SLOTS;
  localparam int unsigned NUM_TASKS  = DEF_NUM_TASKS;
  localparam int unsigned COUNT_BITS = DEF_COUNT_BITS;

  localparam int RANDOM_ITEMS = 1625;
  localparam int HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  // Shadow of the slot table. note_request advances the shadow state by one
  // request and queues the result it must produce; check_result pops the
  // oldest queued result and compares it field by field.
  class timer_table_scoreboard;
    bit                  slot_busy [NUM_SLOTS];
    logic [TASK_W-1:0]   slot_owner[NUM_SLOTS];
    logic [COUNT_BITS-1:0] slot_count[NUM_SLOTS];
    logic [FLAGS_W-1:0]  pending;
    stt_res_t            expected_q[$];
    int                  mismatches;
    int                  results_checked;
    int                  expirations;
    int                  drops;

    function new();
      foreach (slot_busy[s]) slot_busy[s] = 1'b0;
      pending    = '0;
      mismatches = 0;
      results_checked = 0;
      expirations = 0;
      drops = 0;
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                               logic [DELAY_W-1:0] delay);
      stt_res_t res;
      int       hit;
      res = '0;
      hit = -1;
      case (op)
        OP_TICK: begin
          // Expire slots already at zero, count the others down.
          for (int s = 0; s < NUM_SLOTS; s++) begin
            if (slot_busy[s]) begin
              if (slot_count[s] != 0) begin
                slot_count[s] = slot_count[s] - 1'b1;
              end else begin
                res.expired_now[slot_owner[s]] = 1'b1;
                slot_busy[s] = 1'b0;
              end
            end
          end
          pending = pending | res.expired_now;
          if (res.expired_now != '0) expirations++;
        end
        OP_ARM: begin
          if (tid < NUM_TASKS) begin
            // Reload the slot that holds the task, else claim the lowest free one.
            for (int s = 0; s < NUM_SLOTS && hit < 0; s++)
              if (slot_busy[s] && slot_owner[s] == tid) hit = s;
            if (hit < 0) begin
              for (int s = 0; s < NUM_SLOTS && hit < 0; s++)
                if (!slot_busy[s]) hit = s;
              if (hit >= 0) begin
                slot_busy[hit]  = 1'b1;
                slot_owner[hit] = tid;
              end
            end
            if (hit >= 0) begin
              slot_count[hit] = delay[COUNT_BITS-1:0];
            end else begin
              res.set_dropped = 1'b1;
              drops++;
            end
          end
        end
        OP_CLEAR: begin
          if (tid < NUM_TASKS) pending[tid] = 1'b0;
        end
        default: begin
        end
      endcase
      res.pending_flags = pending;
      expected_q.push_back(res);
    endfunction

    function void check_result(stt_res_t got);
      stt_res_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: pending_flags %0h expired_now %0h",
               got.pending_flags, got.expired_now);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      if (got.pending_flags !== want.pending_flags) begin
        $error("pending_flags: expected %0h, got %0h", want.pending_flags, got.pending_flags);
        mismatches++;
      end
      if (got.expired_now !== want.expired_now) begin
        $error("expired_now: expected %0h, got %0h", want.expired_now, got.expired_now);
        mismatches++;
      end
      if (got.set_dropped !== want.set_dropped) begin
        $error("set_dropped: expected %0h, got %0h", want.set_dropped, got.set_dropped);
        mismatches++;
      end
    endfunction
  endclass

  // Clock, reset and block I/O. Every input starts at a known value.
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [OP_W-1:0]      req_op = OP_TICK;
  logic [TASK_W-1:0]    req_task = '0;
  logic [DELAY_W-1:0]   req_delay = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  logic [FLAGS_W-1:0]   res_pending;
  logic [FLAGS_W-1:0]   res_expired;
  logic                 res_dropped;

  timer_table_scoreboard scoreboard = new();

  int requests_sent;
  int input_stall_cycles;
  int cycle_count;
  int send_idle_max;
  int recv_idle_max;
  int recv_wait_left;
  bit hold_off;

  always #1 clk_i = ~clk_i;

  soft_timer_table uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_valid),
    .in_stall_o     (req_stall),
    .op_i           (req_op),
    .task_id_i      (req_task),
    .delay_i        (req_delay),
    .out_valid_o    (res_valid),
    .out_stall_i    (res_stall),
    .pending_flags_o(res_pending),
    .expired_now_o  (res_expired),
    .set_dropped_o  (res_dropped)
  );

  // Offer one request: idle for a random gap, then hold the payload until
  // the block takes it. Called and returns at a falling edge. A zero gap
  // keeps valid high so back-to-back requests see no bubble.
  task automatic send_request(logic [OP_W-1:0] op, logic [TASK_W-1:0] tid,
                              logic [DELAY_W-1:0] delay);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_valid <= 1'b1;
    req_op    <= op;
    req_task  <= tid;
    req_delay <= delay;
    do @(posedge clk_i); while (req_stall);
    scoreboard.note_request(op, tid, delay);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Random request mix. Ticks and arms dominate and delays stay short most of
  // the time, so slots fill, expire and get re-armed often; a few full-width
  // delays and out-of-range task numbers exercise the remaining bits.
  task automatic send_random_request();
    int                 pick;
    logic [OP_W-1:0]    op;
    logic [TASK_W-1:0]  tid;
    logic [DELAY_W-1:0] delay;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 80) op = OP_ARM;
    else if (pick < 95) op = OP_CLEAR;
    else                op = OP_UNUSED;
    if ($urandom_range(0, 9) == 0) tid = TASK_W'($urandom_range(0, 7));
    else                           tid = TASK_W'($urandom_range(0, NUM_TASKS - 1));
    pick = $urandom_range(0, 9);
    if (pick < 7)      delay = DELAY_W'($urandom_range(0, 6));
    else if (pick < 9) delay = DELAY_W'($urandom_range(0, 40));
    else               delay = DELAY_W'($urandom());
    send_request(op, tid, delay);
  endtask

  // Result monitor: sample at the rising edge, check every accepted result,
  // then draw how long to stall before taking the next one.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_valid && req_stall) input_stall_cycles++;
      if (res_valid && !res_stall) begin
        scoreboard.check_result('{pending_flags: res_pending, expired_now: res_expired,
                                  set_dropped: res_dropped});
        // Switch the receiver between eager and sluggish every so often.
        if (scoreboard.results_checked % 128 == 0) begin
          case ($urandom_range(0, 2))
            0: recv_idle_max = 0;
            1: recv_idle_max = 3;
            default: recv_idle_max = 8;
          endcase
        end
        recv_wait_left = $urandom_range(0, recv_idle_max);
      end
    end
  end

  // Drive the result stall at the falling edge; a pressure hold-off wins.
  always @(negedge clk_i) begin
    if (hold_off) begin
      res_stall <= 1'b1;
    end else if (recv_wait_left > 0) begin
      res_stall <= 1'b1;
      recv_wait_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // Back-pressure: twice in the run, hold off the receiver long enough that
  // the two-entry result queue fills and the block stalls its request side.
  initial begin
    hold_off = 1'b0;
    while (requests_sent < 400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
    while (requests_sent < 1100) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               scoreboard.expected_q.size());
      $display("[soft_timer_table] ERROR");
      $finish;
    end
  end

  initial begin
    requests_sent = 0;
    input_stall_cycles = 0;
    cycle_count = 0;
    send_idle_max = 0;
    recv_idle_max = 0;
    recv_wait_left = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Tick and the unused op on an empty table.
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_UNUSED, 3'd7, 16'hFFFF);
    // Zero delay: expires on the very next tick; then clear the flag twice.
    send_request(OP_ARM, 3'd0, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_CLEAR, 3'd0, 16'h0000);
    send_request(OP_CLEAR, 3'd0, 16'h0000);
    // Fill all five slots: longest delay, a re-arm that must not move the
    // slot, and zero delays.
    send_request(OP_ARM, 3'd1, 16'hFFFF);
    send_request(OP_ARM, 3'd2, 16'h0001);
    send_request(OP_ARM, 3'd2, 16'h0002);
    send_request(OP_ARM, 3'd3, 16'h0000);
    send_request(OP_ARM, 3'd4, 16'h0000);
    send_request(OP_ARM, 3'd0, 16'h0000);
    // Out-of-range task numbers: arm and clear are ignored.
    send_request(OP_ARM, 3'd5, 16'h5555);
    send_request(OP_CLEAR, 3'd7, 16'h0000);
    send_request(OP_ARM, 3'd6, 16'hAAAA);
    // Several tasks expire together, then task 2 on the third tick.
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_CLEAR, 3'd3, 16'h0000);
    send_request(OP_UNUSED, 3'd4, 16'h1234);
    // Re-arm the long-running task down to zero so it goes on the next tick.
    send_request(OP_ARM, 3'd1, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);
    send_request(OP_TICK, 3'd0, 16'h0000);

    // Random part, with the sender's idling reshuffled every 150 requests.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        case ($urandom_range(0, 2))
          0: send_idle_max = 0;
          1: send_idle_max = 2;
          default: send_idle_max = 8;
        endcase
      end
      send_random_request();
    end
    req_valid <= 1'b0;

    // Drain every outstanding result, then let the pipeline settle.
    while (scoreboard.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d requests and %0d results in %0d cycles",
             requests_sent, scoreboard.results_checked, cycle_count);
    $display("ticks with expiry: %0d, dropped arms: %0d, request stall cycles: %0d",
             scoreboard.expirations, scoreboard.drops, input_stall_cycles);
    if (scoreboard.mismatches == 0 && scoreboard.expected_q.size() == 0) begin
      $display("[soft_timer_table] OK");
    end else begin
      $display("[soft_timer_table] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/stt_pkg.sv
design/stt_ctrl.sv
design/stt_datapath.sv
design/soft_timer_table.sv
bench/soft_timer_table_tb.sv
